// ===== rtl/core/sfb_pkg.sv =====
// Shared types, codes and constants of the serial flash boot command engine.
// Depends on nothing; every other file of the block but sfb_if refers to it by scoped names.
`default_nettype none

package sfb_pkg;

    // Command bytes received on the serial line.
    localparam logic [7:0] CMD_VERSION = 8'h10;
    localparam logic [7:0] CMD_ACK     = 8'h11;
    localparam logic [7:0] CMD_SIZE    = 8'h12;
    localparam logic [7:0] CMD_ERASE   = 8'h13;
    localparam logic [7:0] CMD_WRITE   = 8'h14;
    localparam logic [7:0] CMD_ALIGN   = 8'h15;
    localparam logic [7:0] CMD_RUN     = 8'h16;

    // Acknowledge byte sent back to the host.
    localparam logic [7:0] ACK_BYTE = 8'h12;

    // Length of the version text held in the ROM below.
    localparam int VERSION_LEN = 10;

    // Sequence step index, wide enough for the longest reply at the largest page.
    localparam int IDX_W = 6;

    // Configuration register indexes and reset values.
    localparam logic [1:0]  REG_TIMEOUT   = 2'd0;
    localparam logic [1:0]  REG_APP_START = 2'd1;
    localparam logic [1:0]  REG_FLASH_END = 2'd2;
    localparam logic [15:0] RST_TIMEOUT   = 16'h1FFF;
    localparam logic [23:0] RST_APP_START = 24'h001000;
    localparam logic [24:0] RST_FLASH_END = 25'h0010000;

    // Result actions.
    typedef enum logic [2:0] {
        ACT_SEND        = 3'd0,
        ACT_ERASE_BLOCK = 3'd1,
        ACT_LOAD_LATCH  = 3'd2,
        ACT_START_WRITE = 3'd3,
        ACT_ERASE_APP   = 3'd4,
        ACT_JUMP        = 3'd5
    } t_action;

    // Controller states.
    typedef enum logic [2:0] {
        ST_WAIT,
        ST_ADDR,
        ST_DATA,
        ST_RUN,
        ST_HALT
    } t_state;

    // Decoded meaning of an incoming beat.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_VERSION,
        OP_ACK,
        OP_SIZE,
        OP_ERASE,
        OP_WRITE,
        OP_ALIGN,
        OP_RUN,
        OP_OTHER
    } t_op;

    // Reply sequences played out by the result sequencer.
    typedef enum logic [2:0] {
        SEQ_VERSION,
        SEQ_ACK,
        SEQ_SIZE,
        SEQ_ALIGN,
        SEQ_REGION,
        SEQ_ACK_JUMP,
        SEQ_JUMP,
        SEQ_PAGE
    } t_seq;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0] timeout_limit;
        logic [23:0] app_start;
        logic [24:0] flash_end;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             accept;
        logic             to_tick;
        logic             start_addr;
        logic             gather_addr;
        logic             gather_data;
        logic             emit;
        logic             last;
        t_seq             seq;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic hit;
        logic addr_end;
        logic data_end;
        logic out_free;
    } t_dp_status;

    // Version text, one character per index.
    function automatic logic [7:0] version_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:    c = 8'h42;  // B
            4'd1:    c = 8'h6F;  // o
            4'd2:    c = 8'h6F;  // o
            4'd3:    c = 8'h74;  // t
            4'd4:    c = 8'h5F;  // _
            4'd5:    c = 8'h31;  // 1
            4'd6:    c = 8'h2E;  // .
            4'd7:    c = 8'h30;  // 0
            4'd8:    c = 8'h2E;  // .
            4'd9:    c = 8'h61;  // a
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sfb_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
// Depends on nothing; payload widths are fixed by the block's field list.
`default_nettype none

// Command channel: one received byte or one idle expiry per beat.
interface sfb_cmd_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, cmd, rx_byte, input ready);
    modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

// Result channel: one transmit byte or one flash action per beat.
interface sfb_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  tx_byte;
    logic [23:0] flash_address;
    logic [24:0] region_end;
    logic [63:0] latch_data;
    logic        last;

    modport source (output valid, action, tx_byte, flash_address, region_end, latch_data,
                    last, input ready);
    modport sink   (input valid, action, tx_byte, flash_address, region_end, latch_data,
                    last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sfb_regs.sv =====
// APB-style configuration registers: timeout limit, application start, flash end.
// Depends on sfb_pkg for the register indexes, reset values and the t_cfg struct.
`default_nettype none

module sfb_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_psel,
    input  wire logic          i_penable,
    input  wire logic          i_pwrite,
    input  wire logic [3:0]    i_paddr,
    input  wire logic [31:0]   i_pwdata,
    output logic [31:0]        o_prdata,
    output logic               o_pready,
    output sfb_pkg::t_cfg      o_cfg
);

    sfb_pkg::t_cfg r_cfg;
    logic          w_write;
    logic [1:0]    w_index;

    // The port never inserts wait states.
    assign o_pready = 1'b1;
    assign w_write  = i_psel && i_penable && i_pwrite;
    assign w_index  = i_paddr[3:2];

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_limit <= sfb_pkg::RST_TIMEOUT;
            r_cfg.app_start     <= sfb_pkg::RST_APP_START;
            r_cfg.flash_end     <= sfb_pkg::RST_FLASH_END;
        end else if (w_write) begin
            case (w_index)
                sfb_pkg::REG_TIMEOUT:   r_cfg.timeout_limit <= i_pwdata[15:0];
                sfb_pkg::REG_APP_START: r_cfg.app_start     <= i_pwdata[23:0];
                sfb_pkg::REG_FLASH_END: r_cfg.flash_end     <= i_pwdata[24:0];
                default: ;
            endcase
        end
    end

    // Read data, zero extended.
    always_comb begin
        case (w_index)
            sfb_pkg::REG_TIMEOUT:   o_prdata = {16'h0, r_cfg.timeout_limit};
            sfb_pkg::REG_APP_START: o_prdata = {8'h0, r_cfg.app_start};
            sfb_pkg::REG_FLASH_END: o_prdata = {7'h0, r_cfg.flash_end};
            default:                o_prdata = 32'h0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/sfb_datapath.sv =====
// Datapath: beat decode, timeout counter, address and page gathering, page store,
// result item assembly and the output register. Depends on sfb_pkg.
`default_nettype none

module sfb_datapath #(
    parameter int PAGE_BYTES    = 64,
    parameter int VERSION_CHARS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd,
    input  wire logic [7:0]         i_rx_byte,
    input  wire sfb_pkg::t_cfg      i_cfg,
    input  wire sfb_pkg::t_dp_cmd   i_ctl,
    output sfb_pkg::t_dp_status     o_status,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [2:0]              o_action,
    output logic [7:0]              o_tx_byte,
    output logic [23:0]             o_flash_address,
    output logic [24:0]             o_region_end,
    output logic [63:0]             o_latch_data,
    output logic                    o_last
);

    localparam int ROWS = (PAGE_BYTES + 7) / 8;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW   = $clog2(PAGE_BYTES);
    localparam int IW   = sfb_pkg::IDX_W;
    localparam int VN   = (VERSION_CHARS < sfb_pkg::VERSION_LEN) ?
                          VERSION_CHARS : sfb_pkg::VERSION_LEN;

    // Size and alignment replies are fixed by the page size.
    localparam logic [8:0]  SIZE_VAL  = 9'(PAGE_BYTES);
    localparam logic [8:0]  ALIGN_VAL = 9'(PAGE_BYTES - 1);
    localparam logic [7:0]  SIZE_HI   = {7'h0, SIZE_VAL[8]};
    localparam logic [7:0]  SIZE_LO   = SIZE_VAL[7:0];
    localparam logic [7:0]  SIZE_SUM  = 8'(sfb_pkg::CMD_SIZE + SIZE_HI + SIZE_LO);
    localparam logic [7:0]  ALIGN_HI  = {7'h0, ALIGN_VAL[8]};
    localparam logic [7:0]  ALIGN_LO  = ALIGN_VAL[7:0];
    localparam logic [7:0]  ALIGN_SUM = 8'(sfb_pkg::CMD_ALIGN + ALIGN_HI + ALIGN_LO);
    localparam logic [9:0]  PAGE_W    = 10'(PAGE_BYTES);
    localparam logic [IW-1:0] LATCHES = IW'(ROWS);

    // Gathering state.
    logic [CW-1:0]  r_cnt;
    logic [23:0]    r_page;
    logic [7:0]     r_rem;
    logic [23:0]    r_base;
    logic [15:0]    r_to_cnt;

    // Page store, one row per latch word.
    logic [63:0]    r_mem [ROWS];
    logic [63:0]    r_rd_data;

    // Output register.
    logic                r_out_valid;
    sfb_pkg::t_action    r_out_action;
    logic [7:0]          r_out_tx;
    logic [23:0]         r_out_addr;
    logic [24:0]         r_out_end;
    logic [63:0]         r_out_data;
    logic                r_out_last;

    logic [7:0]     w_byte;
    logic [15:0]    w_to_base;
    logic [15:0]    w_to_inc;
    logic [9:0]     w_rem_acc;
    logic [7:0]     w_rem_next;
    logic           w_addr_end;
    logic           w_data_end;
    logic [RW-1:0]  w_wrow;
    logic [2:0]     w_lane;
    logic [IW-1:0]  w_rd_k;
    logic [RW-1:0]  w_rrow;
    logic [IW-1:0]  w_lk;
    logic [63:0]    w_lmask;
    sfb_pkg::t_op   w_op;

    sfb_pkg::t_action w_it_action;
    logic [7:0]       w_it_tx;
    logic [23:0]      w_it_addr;
    logic [24:0]      w_it_end;
    logic [63:0]      w_it_data;

    // An idle expiry stands for a zero byte.
    assign w_byte = i_cmd ? 8'h00 : i_rx_byte;

    // Decode of the incoming beat.
    always_comb begin
        if (i_cmd) begin
            w_op = sfb_pkg::OP_IDLE;
        end else begin
            case (i_rx_byte)
                sfb_pkg::CMD_VERSION: w_op = sfb_pkg::OP_VERSION;
                sfb_pkg::CMD_ACK:     w_op = sfb_pkg::OP_ACK;
                sfb_pkg::CMD_SIZE:    w_op = sfb_pkg::OP_SIZE;
                sfb_pkg::CMD_ERASE:   w_op = sfb_pkg::OP_ERASE;
                sfb_pkg::CMD_WRITE:   w_op = sfb_pkg::OP_WRITE;
                sfb_pkg::CMD_ALIGN:   w_op = sfb_pkg::OP_ALIGN;
                sfb_pkg::CMD_RUN:     w_op = sfb_pkg::OP_RUN;
                default:              w_op = sfb_pkg::OP_OTHER;
            endcase
        end
    end

    // A received byte clears the timeout count before any increment.
    assign w_to_base = i_cmd ? r_to_cnt : 16'h0;
    assign w_to_inc  = w_to_base + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_to_cnt <= 16'h0;
        end else if (i_ctl.accept) begin
            r_to_cnt <= i_ctl.to_tick ? w_to_inc : w_to_base;
        end
    end

    // Remainder of the address by the page size, eight restoring steps per byte.
    always_comb begin
        w_rem_acc = {2'b00, r_rem};
        for (int i = 7; i >= 0; i--) begin
            w_rem_acc = {w_rem_acc[8:0], w_byte[i]};
            if (w_rem_acc >= PAGE_W) begin
                w_rem_acc = w_rem_acc - PAGE_W;
            end
        end
        w_rem_next = w_rem_acc[7:0];
    end

    assign w_addr_end = (r_cnt == CW'(3));
    assign w_data_end = (r_cnt == CW'(PAGE_BYTES - 1));

    // Gather counter, page address and its remainder. The first address byte
    // falls off the 24-bit address, so it takes no part in the remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_page <= 24'h0;
            r_rem  <= 8'h0;
        end else if (i_ctl.start_addr) begin
            r_cnt  <= '0;
            r_page <= 24'h0;
            r_rem  <= 8'h0;
        end else if (i_ctl.gather_addr) begin
            r_page <= {r_page[15:0], w_byte};
            r_rem  <= (r_cnt == '0) ? 8'h0 : w_rem_next;
            r_cnt  <= w_addr_end ? '0 : r_cnt + CW'(1);
        end else if (i_ctl.gather_data) begin
            r_cnt  <= w_data_end ? '0 : r_cnt + CW'(1);
        end
    end

    // Block-aligned page address, settled long before the page is written.
    always_ff @(posedge i_clk) begin
        r_base <= r_page - {16'h0, r_rem};
    end

    // Page store: byte writes while gathering, one registered row read a cycle.
    // The row read is that of the next latch word to go out.
    assign w_wrow = RW'(r_cnt >> 3);
    assign w_lane = r_cnt[2:0];
    assign w_rd_k = i_ctl.emit ? i_ctl.idx : i_ctl.idx - IW'(1);
    assign w_rrow = RW'(w_rd_k);

    always_ff @(posedge i_clk) begin
        if (i_ctl.gather_data) begin
            r_mem[w_wrow][{w_lane, 3'b000} +: 8] <= w_byte;
        end
        r_rd_data <= r_mem[w_rrow];
    end

    // Lanes past the end of the page read as zero.
    assign w_lk = i_ctl.idx - IW'(1);
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_lmask[8*i +: 8] = ((10'({w_lk, 3'b000}) + 10'(i)) < PAGE_W) ? 8'hFF : 8'h00;
        end
    end

    // Assembly of the current sequence step.
    always_comb begin
        w_it_action = sfb_pkg::ACT_SEND;
        w_it_tx     = 8'h00;
        w_it_addr   = 24'h0;
        w_it_end    = 25'h0;
        w_it_data   = 64'h0;
        case (i_ctl.seq)
            sfb_pkg::SEQ_VERSION: begin
                if (i_ctl.idx == '0) begin
                    w_it_tx = sfb_pkg::CMD_VERSION;
                end else begin
                    w_it_tx = sfb_pkg::version_char(4'(i_ctl.idx - IW'(1)));
                end
            end
            sfb_pkg::SEQ_ACK: begin
                w_it_tx = sfb_pkg::ACK_BYTE;
            end
            sfb_pkg::SEQ_SIZE: begin
                case (i_ctl.idx[1:0])
                    2'd0:    w_it_tx = sfb_pkg::CMD_SIZE;
                    2'd1:    w_it_tx = SIZE_HI;
                    2'd2:    w_it_tx = SIZE_LO;
                    default: w_it_tx = SIZE_SUM;
                endcase
            end
            sfb_pkg::SEQ_ALIGN: begin
                case (i_ctl.idx[1:0])
                    2'd0:    w_it_tx = sfb_pkg::CMD_ALIGN;
                    2'd1:    w_it_tx = ALIGN_HI;
                    2'd2:    w_it_tx = ALIGN_LO;
                    default: w_it_tx = ALIGN_SUM;
                endcase
            end
            sfb_pkg::SEQ_REGION: begin
                if (i_ctl.idx == '0) begin
                    w_it_action = sfb_pkg::ACT_ERASE_APP;
                    w_it_addr   = i_cfg.app_start;
                    w_it_end    = i_cfg.flash_end;
                end else begin
                    w_it_tx = sfb_pkg::ACK_BYTE;
                end
            end
            sfb_pkg::SEQ_ACK_JUMP: begin
                if (i_ctl.idx == '0) begin
                    w_it_tx = sfb_pkg::ACK_BYTE;
                end else begin
                    w_it_action = sfb_pkg::ACT_JUMP;
                    w_it_addr   = i_cfg.app_start;
                end
            end
            sfb_pkg::SEQ_JUMP: begin
                w_it_action = sfb_pkg::ACT_JUMP;
                w_it_addr   = i_cfg.app_start;
            end
            sfb_pkg::SEQ_PAGE: begin
                if (i_ctl.idx == '0) begin
                    w_it_action = sfb_pkg::ACT_ERASE_BLOCK;
                    w_it_addr   = r_base;
                end else if (i_ctl.idx <= LATCHES) begin
                    w_it_action = sfb_pkg::ACT_LOAD_LATCH;
                    w_it_addr   = r_base + 24'({w_lk, 3'b000});
                    w_it_data   = r_rd_data & w_lmask;
                end else if (i_ctl.idx == LATCHES + IW'(1)) begin
                    w_it_action = sfb_pkg::ACT_START_WRITE;
                    w_it_addr   = r_base;
                end else begin
                    w_it_tx = sfb_pkg::ACK_BYTE;
                end
            end
            default: ;
        endcase
    end

    // Output register: a finished beat waits here while the next one is prepared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out_action <= w_it_action;
            r_out_tx     <= w_it_tx;
            r_out_addr   <= w_it_addr;
            r_out_end    <= w_it_end;
            r_out_data   <= w_it_data;
            r_out_last   <= i_ctl.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_action        = r_out_action;
    assign o_tx_byte       = r_out_tx;
    assign o_flash_address = r_out_addr;
    assign o_region_end    = r_out_end;
    assign o_latch_data    = r_out_data;
    assign o_last          = r_out_last;

    // Status back to the controller.
    assign o_status.op       = w_op;
    assign o_status.hit      = (w_to_inc == i_cfg.timeout_limit);
    assign o_status.addr_end = w_addr_end;
    assign o_status.data_end = w_data_end;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ===== rtl/core/sfb_ctrl.sv =====
// Controller: command phase state machine and result sequencer.
// Depends on sfb_pkg for states, sequences and the datapath command/status structs.
`default_nettype none

module sfb_ctrl #(
    parameter int PAGE_BYTES    = 64,
    parameter int VERSION_CHARS = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire sfb_pkg::t_dp_status i_status,
    output sfb_pkg::t_dp_cmd         o_ctl
);

    localparam int IW   = sfb_pkg::IDX_W;
    localparam int ROWS = (PAGE_BYTES + 7) / 8;
    localparam int VN   = (VERSION_CHARS < sfb_pkg::VERSION_LEN) ?
                          VERSION_CHARS : sfb_pkg::VERSION_LEN;
    localparam logic [IW-1:0] LEN_VERSION = IW'(VN + 1);
    localparam logic [IW-1:0] LEN_PAGE    = IW'(ROWS + 3);

    sfb_pkg::t_state r_state, n_state;
    sfb_pkg::t_seq   r_seq, n_seq;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   w_len;
    logic            w_last;
    logic            w_fire;
    logic            w_count;

    // Number of beats in the running sequence.
    always_comb begin
        case (r_seq)
            sfb_pkg::SEQ_VERSION:  w_len = LEN_VERSION;
            sfb_pkg::SEQ_ACK:      w_len = IW'(1);
            sfb_pkg::SEQ_SIZE:     w_len = IW'(4);
            sfb_pkg::SEQ_ALIGN:    w_len = IW'(4);
            sfb_pkg::SEQ_REGION:   w_len = IW'(2);
            sfb_pkg::SEQ_ACK_JUMP: w_len = IW'(2);
            sfb_pkg::SEQ_JUMP:     w_len = IW'(1);
            sfb_pkg::SEQ_PAGE:     w_len = LEN_PAGE;
            default:               w_len = IW'(1);
        endcase
    end

    assign w_last     = (r_idx == w_len - IW'(1));
    assign o_in_ready = (r_state != sfb_pkg::ST_RUN);
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_count    = (i_status.op == sfb_pkg::OP_IDLE) ||
                        (i_status.op == sfb_pkg::OP_OTHER);

    // Next state.
    always_comb begin
        n_state = r_state;
        n_seq   = r_seq;
        n_idx   = r_idx;
        case (r_state)
            sfb_pkg::ST_WAIT: begin
                if (w_fire) begin
                    n_idx = '0;
                    case (i_status.op)
                        sfb_pkg::OP_VERSION: begin
                            n_state = sfb_pkg::ST_RUN;
                            n_seq   = sfb_pkg::SEQ_VERSION;
                        end
                        sfb_pkg::OP_ACK: begin
                            n_state = sfb_pkg::ST_RUN;
                            n_seq   = sfb_pkg::SEQ_ACK;
                        end
                        sfb_pkg::OP_SIZE: begin
                            n_state = sfb_pkg::ST_RUN;
                            n_seq   = sfb_pkg::SEQ_SIZE;
                        end
                        sfb_pkg::OP_ALIGN: begin
                            n_state = sfb_pkg::ST_RUN;
                            n_seq   = sfb_pkg::SEQ_ALIGN;
                        end
                        sfb_pkg::OP_ERASE: begin
                            n_state = sfb_pkg::ST_RUN;
                            n_seq   = sfb_pkg::SEQ_REGION;
                        end
                        sfb_pkg::OP_RUN: begin
                            n_state = sfb_pkg::ST_RUN;
                            n_seq   = sfb_pkg::SEQ_ACK_JUMP;
                        end
                        sfb_pkg::OP_WRITE: begin
                            n_state = sfb_pkg::ST_ADDR;
                        end
                        default: begin
                            // Idle expiry or unknown byte: jump once the limit is met.
                            if (i_status.hit) begin
                                n_state = sfb_pkg::ST_RUN;
                                n_seq   = sfb_pkg::SEQ_JUMP;
                            end
                        end
                    endcase
                end
            end
            sfb_pkg::ST_ADDR: begin
                if (w_fire && i_status.addr_end) begin
                    n_state = sfb_pkg::ST_DATA;
                end
            end
            sfb_pkg::ST_DATA: begin
                if (w_fire && i_status.data_end) begin
                    n_state = sfb_pkg::ST_RUN;
                    n_seq   = sfb_pkg::SEQ_PAGE;
                    n_idx   = '0;
                end
            end
            sfb_pkg::ST_RUN: begin
                if (i_status.out_free) begin
                    if (w_last) begin
                        if (r_seq == sfb_pkg::SEQ_JUMP || r_seq == sfb_pkg::SEQ_ACK_JUMP) begin
                            n_state = sfb_pkg::ST_HALT;
                        end else begin
                            n_state = sfb_pkg::ST_WAIT;
                        end
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            sfb_pkg::ST_HALT: begin
                n_state = sfb_pkg::ST_HALT;
            end
            default: begin
                n_state = sfb_pkg::ST_WAIT;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_ctl.accept      = w_fire && (r_state != sfb_pkg::ST_HALT);
        o_ctl.to_tick     = w_fire && (r_state == sfb_pkg::ST_WAIT) && w_count;
        o_ctl.start_addr  = w_fire && (r_state == sfb_pkg::ST_WAIT) &&
                            (i_status.op == sfb_pkg::OP_WRITE);
        o_ctl.gather_addr = w_fire && (r_state == sfb_pkg::ST_ADDR);
        o_ctl.gather_data = w_fire && (r_state == sfb_pkg::ST_DATA);
        o_ctl.emit        = (r_state == sfb_pkg::ST_RUN) && i_status.out_free;
        o_ctl.last        = w_last;
        o_ctl.seq         = r_seq;
        o_ctl.idx         = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfb_pkg::ST_WAIT;
            r_seq   <= sfb_pkg::SEQ_ACK;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_seq   <= n_seq;
            r_idx   <= n_idx;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/serial_flash_bootloader_command_engine.sv =====
// Top level of the serial flash boot command engine: registers, controller, datapath.
// Depends on sfb_pkg, sfb_if, sfb_regs, sfb_ctrl and sfb_datapath.
//
//  Channel    Direction  Handshake             Beat
//  i_cmd_ch   in         valid/ready           cmd, rx_byte
//  o_rsp_ch   out        valid/ready           action, tx_byte, flash_address,
//                                              region_end, latch_data, last
//  APB        in/out     psel/penable/pready   timeout_limit, app_start, flash_end
//
// A beat with no result, or one that is gathered, is taken without holding the input.
// A reply holds the input until its last beat is in the single output register;
// the result sequencer sends one beat a cycle while that register is free. A page
// write is 3 + (PAGE_BYTES+7)/8 beats, one page-store row read per latch word.
// Reset is synchronous and needs no clearing pass; the page store is filled
// before its rows are sent out.
`default_nettype none

module serial_flash_bootloader_command_engine #(
    parameter int PAGE_BYTES    = 64,
    parameter int VERSION_CHARS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sfb_cmd_if.sink          i_cmd_ch,
    sfb_rsp_if.source        o_rsp_ch,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    sfb_pkg::t_cfg       w_cfg;
    sfb_pkg::t_dp_cmd    w_ctl;
    sfb_pkg::t_dp_status w_status;

    // Configuration registers.
    sfb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    // Phase state machine and result sequencer.
    sfb_ctrl #(
        .PAGE_BYTES    (PAGE_BYTES),
        .VERSION_CHARS (VERSION_CHARS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd_ch.valid),
        .o_in_ready (i_cmd_ch.ready),
        .i_status   (w_status),
        .o_ctl      (w_ctl)
    );

    // Gathering, page store and result assembly.
    sfb_datapath #(
        .PAGE_BYTES    (PAGE_BYTES),
        .VERSION_CHARS (VERSION_CHARS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (i_cmd_ch.cmd),
        .i_rx_byte       (i_cmd_ch.rx_byte),
        .i_cfg           (w_cfg),
        .i_ctl           (w_ctl),
        .o_status        (w_status),
        .i_out_ready     (o_rsp_ch.ready),
        .o_out_valid     (o_rsp_ch.valid),
        .o_action        (o_rsp_ch.action),
        .o_tx_byte       (o_rsp_ch.tx_byte),
        .o_flash_address (o_rsp_ch.flash_address),
        .o_region_end    (o_rsp_ch.region_end),
        .o_latch_data    (o_rsp_ch.latch_data),
        .o_last          (o_rsp_ch.last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/sfb_checker.sv =====
// Port-level checks of the command engine and the bind that attaches them.
// Depends on sfb_pkg for the action codes and on the top level's port names.
`default_nettype none

module sfb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_out_action,
    input wire logic [7:0]  i_out_tx,
    input wire logic [23:0] i_out_addr,
    input wire logic [63:0] i_out_data,
    input wire logic        i_out_last
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result beat present after reset");

    // A stalled result beat holds its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_action) &&
        $stable(i_out_tx) && $stable(i_out_addr) && $stable(i_out_data) && $stable(i_out_last))
        else $error("stalled result beat changed");

    // While a reply is unfinished no new command beat is taken.
    a_reply_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("command taken in the middle of a reply");

    // A jump always closes its reply.
    a_jump_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_action == sfb_pkg::ACT_JUMP) |-> i_out_last)
        else $error("jump not marked as final beat");

    // Once the jump has been taken the engine stays silent.
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_out_action == sfb_pkg::ACT_JUMP) |=> !i_out_valid)
        else $error("result beat after jump");

endmodule

bind serial_flash_bootloader_command_engine sfb_checker u_sfb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_cmd_ch.ready),
    .i_out_valid  (o_rsp_ch.valid),
    .i_out_ready  (o_rsp_ch.ready),
    .i_out_action (o_rsp_ch.action),
    .i_out_tx     (o_rsp_ch.tx_byte),
    .i_out_addr   (o_rsp_ch.flash_address),
    .i_out_data   (o_rsp_ch.latch_data),
    .i_out_last   (o_rsp_ch.last)
);

`default_nettype wire
